FILE: hdl/sv39m_pkg.sv
package sv39m_pkg;

    // Pool geometry.
    localparam int NUM_TABLES        = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int SLOT_W            = $clog2(NUM_TABLES);
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int TU_W              = $clog2(NUM_TABLES + 1);
    localparam int ADDR_W            = SLOT_W + IDX_W;
    localparam int PTE_W             = 64;

    // Field widths.
    localparam int PPN_W   = 44;
    localparam int VPN_W   = 27;
    localparam int PAGES_W = 28;
    localparam int FLAGS_W = 10;

    // Walk levels.
    localparam logic [1:0] LEVEL_ROOT = 2'd0;
    localparam logic [1:0] LEVEL_LAST = 2'd2;

    // Commands.
    localparam logic CMD_MAP  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_INVAL = 3'd1;
    localparam logic [2:0] ST_NOMEM = 3'd2;
    localparam logic [2:0] ST_EXIST = 3'd3;
    localparam logic [2:0] ST_FAULT = 3'd4;

    localparam logic [3:0] SATP_MODE_PAGED = 4'd8;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [PTE_W-1:0]  t_pte;

endpackage

FILE: hdl/sv39m_ram.sv
module sv39m_ram #(
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 15
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/sv39_page_table_mapper_core.sv
// Sv39 page table mapper. A command is taken when start is high and busy is
// low. A map command (i_cmd = 0) walks the three table levels for each 4 KiB
// page of the range, allocating zeroed table pages from a pool of 64 as it
// goes; a read command (i_cmd = 1) returns one stored entry. Every command
// produces exactly one result, shown on the o_ ports for a single cycle with
// o_done high; the receiver cannot stall it and must take the transfer then.
// A read goes through the states S_RD and S_RD_DATA. A map visits each table
// level of each page as a read in S_WALK_RD followed by a check and, where
// needed, a write in S_WALK_CHK, as the table memory has a registered read port.
// After reset the block clears the whole table memory, all 32768 entries, one
// entry per cycle, and holds busy high meanwhile; configuration writes are taken
// at any time but must only be made while the block is idle.
module sv39_page_table_mapper_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         i_cfg_we,
    input  logic [43:0]  i_cfg_wdata,
    input  logic         i_cmd,
    input  logic [38:0]  i_virt_addr,
    input  logic [55:0]  i_phys_addr,
    input  logic [39:0]  i_size_bytes,
    input  logic [9:0]   i_prot_flags,
    input  logic [5:0]   i_table_slot,
    input  logic [8:0]   i_entry_index,
    output logic         o_done,
    output logic [2:0]   o_status,
    output logic [63:0]  o_satp_value,
    output logic [63:0]  o_entry_value
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_RD       = 3'd2;
    localparam logic [2:0] S_RD_DATA  = 3'd3;
    localparam logic [2:0] S_WALK_RD  = 3'd4;
    localparam logic [2:0] S_WALK_CHK = 3'd5;

    // Control state.
    logic [2:0]                     r_state, n_state;
    logic [sv39m_pkg::ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [sv39m_pkg::TU_W-1:0]     r_tu, n_tu;
    logic                           r_root, n_root;
    logic [sv39m_pkg::PPN_W-1:0]    r_base;
    logic                           r_done, n_done;

    // Command payload and walk position.
    logic [sv39m_pkg::ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic [sv39m_pkg::VPN_W-1:0]    r_vpn, n_vpn;
    logic [sv39m_pkg::PPN_W-1:0]    r_ppn, n_ppn;
    logic [sv39m_pkg::PAGES_W-1:0]  r_pages, n_pages;
    logic [sv39m_pkg::FLAGS_W-1:0]  r_flags, n_flags;
    logic [1:0]                     r_level, n_level;
    logic [sv39m_pkg::SLOT_W-1:0]   r_slot, n_slot;

    // Result registers.
    logic [2:0]  r_status, n_status;
    logic [63:0] r_satp, n_satp;
    logic [63:0] r_entry, n_entry;

    // Memory port.
    logic                         mem_we;
    sv39m_pkg::t_addr             mem_waddr;
    sv39m_pkg::t_pte              mem_wdata;
    sv39m_pkg::t_addr             mem_raddr;
    sv39m_pkg::t_pte              mem_rdata;

    logic [sv39m_pkg::IDX_W-1:0]  walk_idx;
    sv39m_pkg::t_addr             walk_addr;
    logic [sv39m_pkg::PPN_W-1:0]  fresh_ppn;
    logic [sv39m_pkg::PPN_W-1:0]  link_rel;
    logic                         link_in_pool;

    sv39m_ram #(
        .WIDTH  (sv39m_pkg::PTE_W),
        .ADDR_W (sv39m_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Index of the current level: level 0 uses VPN[2], the last level VPN[0].
    always_comb begin
        unique case (r_level)
            2'd0:    walk_idx = r_vpn[26:18];
            2'd1:    walk_idx = r_vpn[17:9];
            default: walk_idx = r_vpn[8:0];
        endcase
    end

    assign walk_addr = {r_slot, walk_idx};

    // Page number of the next free pool slot, wrapping at 44 bits.
    assign fresh_ppn = r_base + sv39m_pkg::PPN_W'(r_tu);

    // A valid link must point at an allocated slot relative to the pool base.
    assign link_rel     = mem_rdata[53:10] - r_base;
    assign link_in_pool = (link_rel[sv39m_pkg::PPN_W-1:sv39m_pkg::TU_W] == '0)
                          && (link_rel[sv39m_pkg::TU_W-1:0] < r_tu);

    assign mem_raddr = (r_state == S_RD) ? r_rd_addr : walk_addr;

    always_comb begin
        n_state   = r_state;
        n_clr_addr = r_clr_addr;
        n_tu      = r_tu;
        n_root    = r_root;
        n_done    = 1'b0;
        n_rd_addr = r_rd_addr;
        n_vpn     = r_vpn;
        n_ppn     = r_ppn;
        n_pages   = r_pages;
        n_flags   = r_flags;
        n_level   = r_level;
        n_slot    = r_slot;
        n_status  = r_status;
        n_satp    = r_satp;
        n_entry   = r_entry;
        mem_we    = 1'b0;
        mem_waddr = walk_addr;
        mem_wdata = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + sv39m_pkg::ADDR_W'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_cmd == sv39m_pkg::CMD_READ) begin
                        n_rd_addr = {i_table_slot, i_entry_index};
                        n_state   = S_RD;
                    end else if ((i_virt_addr[11:0] != i_phys_addr[11:0])
                                 || (i_size_bytes[11:0] != 12'd0)) begin
                        n_status = sv39m_pkg::ST_INVAL;
                        n_entry  = '0;
                        n_done   = 1'b1;
                    end else begin
                        // The root is always the first table taken from the pool.
                        if (!r_root) begin
                            n_root = 1'b1;
                            n_tu   = sv39m_pkg::TU_W'(1);
                        end
                        n_vpn   = i_virt_addr[38:12];
                        n_ppn   = i_phys_addr[55:12];
                        n_pages = i_size_bytes[39:12];
                        n_flags = i_prot_flags;
                        n_level = sv39m_pkg::LEVEL_ROOT;
                        n_slot  = '0;
                        n_entry = '0;
                        if (i_size_bytes[39:12] == '0) begin
                            n_status = sv39m_pkg::ST_OK;
                            n_done   = 1'b1;
                        end else begin
                            n_state = S_WALK_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_entry  = mem_rdata;
                n_status = sv39m_pkg::ST_OK;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_WALK_RD: begin
                n_state = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                n_state = S_IDLE;
                if (!mem_rdata[0]) begin
                    if (r_level == sv39m_pkg::LEVEL_LAST) begin
                        mem_we    = 1'b1;
                        mem_wdata = {10'd0, r_ppn, r_flags};
                        if (r_pages == sv39m_pkg::PAGES_W'(1)) begin
                            n_status = sv39m_pkg::ST_OK;
                            n_done   = 1'b1;
                        end else begin
                            n_pages = r_pages - sv39m_pkg::PAGES_W'(1);
                            n_vpn   = r_vpn + sv39m_pkg::VPN_W'(1);
                            n_ppn   = r_ppn + sv39m_pkg::PPN_W'(1);
                            n_level = sv39m_pkg::LEVEL_ROOT;
                            n_slot  = '0;
                            n_state = S_WALK_RD;
                        end
                    end else if (r_tu >= sv39m_pkg::TU_W'(sv39m_pkg::NUM_TABLES)) begin
                        n_status = sv39m_pkg::ST_NOMEM;
                        n_done   = 1'b1;
                    end else begin
                        // Link a fresh table; it is already zero from the clear pass.
                        mem_we    = 1'b1;
                        mem_wdata = {10'd0, fresh_ppn, 10'd1};
                        n_slot    = r_tu[sv39m_pkg::SLOT_W-1:0];
                        n_tu      = r_tu + sv39m_pkg::TU_W'(1);
                        n_level   = r_level + 2'd1;
                        n_state   = S_WALK_RD;
                    end
                end else if (r_level == sv39m_pkg::LEVEL_LAST) begin
                    n_status = sv39m_pkg::ST_EXIST;
                    n_done   = 1'b1;
                end else if ((mem_rdata[3:1] != 3'd0) || !link_in_pool) begin
                    n_status = sv39m_pkg::ST_FAULT;
                    n_done   = 1'b1;
                end else begin
                    n_slot  = link_rel[sv39m_pkg::SLOT_W-1:0];
                    n_level = r_level + 2'd1;
                    n_state = S_WALK_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_done) begin
            n_satp = n_root ? {sv39m_pkg::SATP_MODE_PAGED, 16'd0, r_base} : 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_tu       <= '0;
            r_root     <= 1'b0;
            r_base     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_tu       <= n_tu;
            r_root     <= n_root;
            r_done     <= n_done;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_vpn     <= n_vpn;
        r_ppn     <= n_ppn;
        r_pages   <= n_pages;
        r_flags   <= n_flags;
        r_level   <= n_level;
        r_slot    <= n_slot;
        r_status  <= n_status;
        r_satp    <= n_satp;
        r_entry   <= n_entry;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_satp_value  = r_satp;
    assign o_entry_value = r_entry;

endmodule

FILE: test/tb.sv
module tb;

    // One command as it is handed to the block.
    typedef struct {
        logic        cmd;
        logic [38:0] va;
        logic [55:0] pa;
        logic [39:0] size;
        logic [9:0]  flags;
        logic [5:0]  slot;
        logic [8:0]  idx;
    } t_mapper_cmd;

    // One result as the block reports it.
    typedef struct {
        logic [2:0]  status;
        logic [63:0] satp;
        logic [63:0] entry;
    } t_mapper_res;

    localparam logic [63:0] PPN_MASK  = 64'h0000_0fff_ffff_ffff;
    localparam logic [63:0] VA_MASK   = 64'h0000_007f_ffff_ffff;
    localparam logic [63:0] PA_MASK   = 64'h00ff_ffff_ffff_ffff;
    localparam logic [43:0] BASE_MAX  = 44'hfff_ffff_ffff;
    localparam int          STALL_MAX = 100000;
    localparam int          TBL_N     = sv39m_pkg::NUM_TABLES;
    localparam int          ENT_N     = sv39m_pkg::ENTRIES_PER_TABLE;

    // The class keeps its own copy of the table pool and works out the
    // result of every accepted command from it.
    class page_table_tracker;
        logic [63:0] tables[0:TBL_N*ENT_N-1];
        int          used;
        bit          root;
        logic [43:0] base;
        t_mapper_res pending_q[$];
        int          mismatches;

        function new();
            foreach (tables[i]) tables[i] = '0;
            used = 0;
            root = 0;
            base = '0;
            mismatches = 0;
        endfunction

        function bit grab_table(output int slot);
            if (used >= TBL_N) return 0;
            slot = used;
            used++;
            for (int i = 0; i < ENT_N; i++) tables[slot*ENT_N+i] = '0;
            return 1;
        endfunction

        function logic [63:0] slot_page(int slot);
            return (64'(base) + 64'(slot)) & PPN_MASK;
        endfunction

        function logic [2:0] walk_page(logic [63:0] va, logic [63:0] pa, logic [9:0] flags);
            int          slot;
            int          fresh;
            int          pos;
            logic [63:0] e;
            logic [63:0] rel;
            slot = 0;
            for (int lvl = 0; lvl < 3; lvl++) begin
                pos = slot * ENT_N + int'((va >> (12 + 9 * (2 - lvl))) & 64'h1ff);
                e = tables[pos];
                if (!e[0]) begin
                    if (lvl == 2) begin
                        tables[pos] = (((pa >> 12) & PPN_MASK) << 10) | 64'(flags);
                        return sv39m_pkg::ST_OK;
                    end
                    if (!grab_table(fresh)) return sv39m_pkg::ST_NOMEM;
                    tables[pos] = (slot_page(fresh) << 10) | 64'h1;
                    slot = fresh;
                end else begin
                    if (lvl == 2) return sv39m_pkg::ST_EXIST;
                    if ((e & 64'he) != 0) return sv39m_pkg::ST_FAULT;
                    rel = (((e >> 10) & PPN_MASK) - 64'(base)) & PPN_MASK;
                    if (rel >= 64'(used)) return sv39m_pkg::ST_FAULT;
                    slot = int'(rel);
                end
            end
            return sv39m_pkg::ST_FAULT;
        endfunction

        function logic [2:0] map_span(t_mapper_cmd c);
            logic [63:0] va;
            logic [63:0] pa;
            logic [27:0] pages;
            logic [2:0]  st;
            int          r;
            if (c.va[11:0] != c.pa[11:0]) return sv39m_pkg::ST_INVAL;
            if (c.size[11:0] != 0) return sv39m_pkg::ST_INVAL;
            if (!root) begin
                if (!grab_table(r)) return sv39m_pkg::ST_NOMEM;
                root = 1;
            end
            va = 64'(c.va) & ~64'hfff;
            pa = 64'(c.pa) & ~64'hfff;
            for (pages = c.size[39:12]; pages > 0; pages--) begin
                st = walk_page(va, pa, c.flags);
                if (st != sv39m_pkg::ST_OK) return st;
                va = (va + 64'd4096) & VA_MASK;
                pa = (pa + 64'd4096) & PA_MASK;
            end
            return sv39m_pkg::ST_OK;
        endfunction

        function void note_command(t_mapper_cmd c);
            t_mapper_res r;
            r.entry = '0;
            r.status = sv39m_pkg::ST_OK;
            if (c.cmd == sv39m_pkg::CMD_MAP) r.status = map_span(c);
            else r.entry = tables[int'(c.slot) * ENT_N + int'(c.idx)];
            r.satp = root ? ({sv39m_pkg::SATP_MODE_PAGED, 60'd0} | slot_page(0)) : '0;
            pending_q.push_back(r);
        endfunction

        function void check_result(t_mapper_res got);
            t_mapper_res want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d satp %h entry %h",
                             got.status, got.satp, got.entry);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status || got.satp !== want.satp
                    || got.entry !== want.entry) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Result mismatch: expected status %0d satp %h entry %h,",
                              " got status %0d satp %h entry %h"},
                             want.status, want.satp, want.entry,
                             got.status, got.satp, got.entry);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [43:0] i_cfg_wdata;
    logic        i_cmd;
    logic [38:0] i_virt_addr;
    logic [55:0] i_phys_addr;
    logic [39:0] i_size_bytes;
    logic [9:0]  i_prot_flags;
    logic [5:0]  i_table_slot;
    logic [8:0]  i_entry_index;
    logic        o_done;
    logic [2:0]  o_status;
    logic [63:0] o_satp_value;
    logic [63:0] o_entry_value;

    page_table_tracker tracker;
    int                idle_pct;
    int                stall_cycles;

    sv39_page_table_mapper_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_cmd),
        .i_virt_addr   (i_virt_addr),
        .i_phys_addr   (i_phys_addr),
        .i_size_bytes  (i_size_bytes),
        .i_prot_flags  (i_prot_flags),
        .i_table_slot  (i_table_slot),
        .i_entry_index (i_entry_index),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_satp_value  (o_satp_value),
        .o_entry_value (o_entry_value)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Every result is on the ports for one cycle only, so it is taken at the
    // edge that ends that cycle. The block never runs two commands at once,
    // so results come back in command order.
    always @(posedge i_clk) begin
        t_mapper_res got;
        if (i_rst_n && o_done) begin
            got.status = o_status;
            got.satp   = o_satp_value;
            got.entry  = o_entry_value;
            tracker.check_result(got);
        end
    end

    // The watchdog counts cycles with no transfer on either side. The limit
    // covers the memory clearing pass after reset several times over.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Drives one command and holds it until the block takes it. The start
    // line stays high into the next command when no idle gap follows.
    task automatic send_cmd(t_mapper_cmd c);
        int gap;
        start         <= 1'b1;
        i_cmd         <= c.cmd;
        i_virt_addr   <= c.va;
        i_phys_addr   <= c.pa;
        i_size_bytes  <= c.size;
        i_prot_flags  <= c.flags;
        i_table_slot  <= c.slot;
        i_entry_index <= c.idx;
        do begin
            @(posedge i_clk);
        end while (busy);
        tracker.note_command(c);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lowers start, lets every outstanding result come back, and only then
    // changes the pool base.
    task automatic set_pool_base(logic [43:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.base = value;
    endtask

    function automatic t_mapper_cmd map_of(logic [38:0] va, logic [55:0] pa,
                                           logic [39:0] size, logic [9:0] flags);
        t_mapper_cmd c;
        c.cmd = sv39m_pkg::CMD_MAP;
        c.va = va;
        c.pa = pa;
        c.size = size;
        c.flags = flags;
        c.slot = 6'($urandom);
        c.idx = 9'($urandom);
        return c;
    endfunction

    function automatic t_mapper_cmd read_of(logic [5:0] slot, logic [8:0] idx);
        t_mapper_cmd c;
        c = map_of(39'({$urandom, $urandom}), 56'({$urandom, $urandom}),
                   40'({$urandom, $urandom}), 10'($urandom));
        c.cmd = sv39m_pkg::CMD_READ;
        c.slot = slot;
        c.idx = idx;
        return c;
    endfunction

    // Most random maps land in a handful of gigapage and megapage regions so
    // the walks reuse tables, run into existing leaves and, over time, drain
    // the pool. The rest is reads and badly formed maps with random bits.
    function automatic t_mapper_cmd random_cmd();
        t_mapper_cmd c;
        logic [38:0] va;
        logic [55:0] pa;
        logic [11:0] off;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            off = 12'($urandom);
            va = {2'($urandom), 7'd0, 2'($urandom), 7'd0, 9'($urandom), off};
            if ($urandom_range(9) == 0) va = {27'($urandom), off};
            pa = {44'({$urandom, $urandom}), off};
            c = map_of(va, pa, {28'($urandom_range(4)), 12'd0}, 10'($urandom) | 10'h1);
            if ($urandom_range(7) == 0) c.flags = 10'($urandom);
        end else if (pick < 85) begin
            c = read_of($urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(24)),
                        9'($urandom));
        end else begin
            c = map_of(39'({$urandom, $urandom}), 56'({$urandom, $urandom}),
                       40'({$urandom, $urandom}) | 40'(1 << $urandom_range(11)),
                       10'($urandom));
            if ($urandom_range(1) == 0) begin
                c.pa[11:0] = c.va[11:0];
            end
        end
        return c;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_cmd(random_cmd());
    endtask

    initial begin
        tracker       = new();
        idle_pct      = 0;
        stall_cycles  = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_cmd         = sv39m_pkg::CMD_MAP;
        i_virt_addr   = '0;
        i_phys_addr   = '0;
        i_size_bytes  = '0;
        i_prot_flags  = '0;
        i_table_slot  = '0;
        i_entry_index = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_pool_base(44'd0);

        // Directed commands: no root yet, zero size, page offsets that do not
        // match, an unaligned size, an existing leaf hit by the largest range,
        // a leaf without V that is later overwritten, and wrapping addresses.
        send_cmd(read_of(6'd0, 9'd0));
        send_cmd(map_of(39'd0, 56'd0, 40'd0, 10'h3ff));
        send_cmd(map_of(39'h123, 56'h456, 40'h1000, 10'h0cf));
        send_cmd(map_of(39'd0, 56'd0, 40'h1001, 10'h0cf));
        send_cmd(map_of(39'h0000001abc, 56'hff_ffff_ffff_fabc, 40'h2000, 10'h3ff));
        send_cmd(map_of(39'h0000001000, 56'd0, 40'hff_ffff_f000, 10'h001));
        send_cmd(map_of(39'h0000100000, 56'h12_3456_7800_0000, 40'h1000, 10'h00e));
        send_cmd(map_of(39'h0000100000, 56'h00_0000_0001_0000, 40'h1000, 10'h3c7));
        send_cmd(map_of(39'h7f_ffff_f000, 56'hff_ffff_ffff_f000, 40'h2000, 10'h0d7));
        send_cmd(map_of(39'h7f_ffff_e000, 56'h00_0000_0000_0000, 40'h1000, 10'h000));
        send_cmd(read_of(6'd0, 9'd0));
        send_cmd(read_of(6'd0, 9'd511));
        send_cmd(read_of(6'd2, 9'd1));
        send_cmd(read_of(6'd2, 9'd256));
        send_cmd(read_of(6'd63, 9'd511));
        send_cmd(read_of(6'd4, 9'd511));

        run_random(170);

        // Moving the pool base shifts where every stored link points.
        set_pool_base(BASE_MAX);
        idle_pct = 83;
        send_cmd(map_of(39'd0, 56'd0, 40'h1000, 10'h0cf));
        run_random(170);

        set_pool_base(44'({$urandom, $urandom}));
        idle_pct = 0;
        run_random(170);

        set_pool_base(44'd0);
        idle_pct = 27;
        run_random(170);

        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
